/* sv/cci_pkg.sv */
`timescale 1ns / 1ps

package cci_pkg;

    // Field widths
    localparam int ADDR_W   = 28;
    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int SIZE_W   = 2;
    localparam int OP_W     = 4;
    localparam int CFG_IDX_W = 1;

    // Opcodes held in the top nibble of the address word
    localparam logic [OP_W-1:0] OP_WRITE32 = 4'h0;
    localparam logic [OP_W-1:0] OP_WRITE16 = 4'h1;
    localparam logic [OP_W-1:0] OP_WRITE8  = 4'h2;
    localparam logic [OP_W-1:0] OP_IF_EQ16 = 4'h9;
    localparam logic [OP_W-1:0] OP_END_IF  = 4'hD;

    // Write size codes
    localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHEAT_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_MASK     = 1'd1;

    // Reset values of the configuration registers
    localparam logic              CHEAT_ENABLE_RST = 1'b1;
    localparam logic [ADDR_W-1:0] RAM_MASK_RST     = 28'h03F_FFFF;

    // One code pair
    typedef struct packed {
        logic [WORD_W-1:0] code_address_word;
        logic [WORD_W-1:0] code_value_word;
        logic [HALF_W-1:0] memory_halfword;
        logic              last_pair;
    } code_t;

    // One result
    typedef struct packed {
        logic              write_request;
        logic [ADDR_W-1:0] write_address;
        logic [WORD_W-1:0] write_data;
        logic [SIZE_W-1:0] write_size;
        logic              condition_true;
    } result_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic              cheat_enable;
        logic [ADDR_W-1:0] ram_address_mask;
    } cfg_t;

endpackage

/* sv/cheat_code_interpreter_unit.sv */
`timescale 1ns / 1ps

// Cheat code interpreter: takes one code pair per beat on the code channel and
// returns exactly one result per pair on the result channel, in order. A pair
// is held in the input register, is decoded against the condition flag in a
// single pass, and lands in the result register. A new pair is taken every
// cycle while the result side keeps up; the flag update in that one decode
// pass is what sets the rate. Configuration writes are accepted at any time
// (cfg_ready is always high) but are meant to be done while no pair is in
// flight.
module cheat_code_interpreter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // code pair channel
    input  logic                          code_valid,
    output logic                          code_stall,
    input  cci_pkg::code_t                code,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output cci_pkg::result_t              result,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cci_pkg::ADDR_W-1:0]    cfg_data
);

    cci_pkg::cfg_t    cfg;
    cci_pkg::code_t   code_reg;
    logic             code_valid_reg;
    cci_pkg::result_t result_reg;
    cci_pkg::result_t result_next;
    logic             result_valid_reg;
    logic             flag_reg;
    logic             flag_next;
    logic             res_free;
    logic             advance;

    assign cfg_ready = 1'b1;

    cci_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cci_decode u_decode (
        .code      (code_reg),
        .cfg       (cfg),
        .flag      (flag_reg),
        .result    (result_next),
        .flag_next (flag_next)
    );

    // Pipeline flow control
    assign res_free   = !result_valid_reg || !result_stall;
    assign advance    = code_valid_reg && res_free;
    assign code_stall = code_valid_reg && !res_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_valid_reg <= 1'b0;
        else if (!code_stall)
            code_valid_reg <= code_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!code_stall && code_valid)
            code_reg <= code;
    end

    // Condition flag, moves once per decoded pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_reg <= 1'b1;
        else if (advance)
            flag_reg <= flag_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (res_free)
            result_valid_reg <= code_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* sv/cci_config.sv */
`timescale 1ns / 1ps

module cci_config (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [cci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cci_pkg::ADDR_W-1:0]     cfg_data,
    output cci_pkg::cfg_t                  cfg
);

    logic                       cheat_enable_reg;
    logic [cci_pkg::ADDR_W-1:0] ram_mask_reg;

    // Register writes, one per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cheat_enable_reg <= cci_pkg::CHEAT_ENABLE_RST;
            ram_mask_reg     <= cci_pkg::RAM_MASK_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cci_pkg::CFG_CHEAT_ENABLE: cheat_enable_reg <= cfg_data[0];
                cci_pkg::CFG_RAM_MASK:     ram_mask_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.cheat_enable     = cheat_enable_reg;
    assign cfg.ram_address_mask = ram_mask_reg;

endmodule

/* sv/cci_decode.sv */
`timescale 1ns / 1ps

module cci_decode (
    input  cci_pkg::code_t   code,
    input  cci_pkg::cfg_t    cfg,
    input  logic             flag,
    output cci_pkg::result_t result,
    output logic             flag_next
);

    logic [cci_pkg::OP_W-1:0]   op;
    logic [cci_pkg::HALF_W-1:0] cmp_mask;
    logic [cci_pkg::HALF_W-1:0] cmp_value;
    logic                       cond;
    logic                       do_write;

    assign op        = code.code_address_word[cci_pkg::WORD_W-1 -: cci_pkg::OP_W];
    assign cmp_mask  = code.code_value_word[cci_pkg::WORD_W-1 -: cci_pkg::HALF_W];
    assign cmp_value = code.code_value_word[cci_pkg::HALF_W-1:0];
    assign do_write  = flag & cfg.cheat_enable;

    // Opcode decode: writes gated by flag and cheat enable, compare reloads flag, end-if sets it
    always_comb
    begin
        result = '0;
        cond   = flag;
        unique case (op) inside
            cci_pkg::OP_WRITE32, cci_pkg::OP_WRITE16, cci_pkg::OP_WRITE8:
            begin
                if (do_write)
                begin
                    result.write_request = 1'b1;
                    result.write_address =
                        code.code_address_word[cci_pkg::ADDR_W-1:0] & cfg.ram_address_mask;
                    if (op == cci_pkg::OP_WRITE32)
                    begin
                        result.write_size = cci_pkg::SIZE_WORD;
                        result.write_data = code.code_value_word;
                    end
                    else if (op == cci_pkg::OP_WRITE16)
                    begin
                        result.write_size = cci_pkg::SIZE_HALF;
                        result.write_data = {16'h0000, code.code_value_word[15:0]};
                    end
                    else
                    begin
                        result.write_size = cci_pkg::SIZE_BYTE;
                        result.write_data = {24'h00_0000, code.code_value_word[7:0]};
                    end
                end
            end
            cci_pkg::OP_IF_EQ16:
                cond = ((code.memory_halfword & ~cmp_mask) == cmp_value);
            cci_pkg::OP_END_IF:
                cond = 1'b1;
            default: ;
        endcase
        result.condition_true = cond;
    end

    // End of cheat makes the flag true again
    assign flag_next = cond | code.last_pair;

endmodule

/* sv/cci_checker.sv */
`timescale 1ns / 1ps

module cci_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_valid,
    input  logic             result_stall,
    input  cci_pkg::result_t result
);

    // A held result beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // No write means empty write fields
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.write_request |->
            result.write_address == '0 && result.write_data == '0 &&
            result.write_size == cci_pkg::SIZE_WORD)
        else $error("write fields set without a request");

    // Size code legal and data cut to size
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_request |->
            (result.write_size == cci_pkg::SIZE_WORD) ||
            (result.write_size == cci_pkg::SIZE_HALF && result.write_data[31:16] == '0) ||
            (result.write_size == cci_pkg::SIZE_BYTE && result.write_data[31:8] == '0))
        else $error("bad write size or data");

    // A write only happens under a true condition
    a_cond: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_request |-> result.condition_true)
        else $error("write under false condition");

endmodule

bind cheat_code_interpreter_unit cci_checker u_cci_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

/* test/cheat_code_interpreter_unit_test.sv */
`timescale 1ns / 1ps

module cheat_code_interpreter_unit_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 8;
    localparam int PAIRS_PER_PHASE = 155;

    // One row of the directed table
    typedef struct {
        cci_pkg::code_t   pair;
        bit               known;
        cci_pkg::result_t outcome;
    } plan_row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             code_valid = 1'b0;
    logic             code_stall;
    cci_pkg::code_t   code = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    cci_pkg::result_t result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [cci_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cci_pkg::ADDR_W-1:0]    cfg_data = '0;

    // Hand-written expectation travelling with the beat on the code channel
    bit               code_known = 1'b0;
    cci_pkg::result_t code_known_outcome = '0;

    // Mirror of the block's flag and registers
    bit                         flag_model;
    bit                         enable_model;
    logic [cci_pkg::ADDR_W-1:0] mask_model;

    cci_pkg::result_t outcome_q[$];
    plan_row_t plan[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int cycles = 0;
    int pairs_seen = 0;
    int writes_seen = 0;
    int false_conds = 0;
    int phases_run = 0;

    cheat_code_interpreter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .code         (code),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, outcome_q.size());
            $display("cheat_code_interpreter_unit_test: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // Decode one pair against the mirrored flag and registers
    function automatic cci_pkg::result_t interpret_pair(input cci_pkg::code_t p);
        cci_pkg::result_t r;
        logic [cci_pkg::OP_W-1:0] op;
        logic [15:0] care;
        r  = '0;
        op = p.code_address_word[31:28];
        case (op)
            cci_pkg::OP_WRITE32, cci_pkg::OP_WRITE16, cci_pkg::OP_WRITE8:
            begin
                if (flag_model && enable_model)
                begin
                    r.write_request = 1'b1;
                    r.write_address = p.code_address_word[cci_pkg::ADDR_W-1:0] & mask_model;
                    if (op == cci_pkg::OP_WRITE32)
                    begin
                        r.write_data = p.code_value_word;
                        r.write_size = cci_pkg::SIZE_WORD;
                    end
                    else if (op == cci_pkg::OP_WRITE16)
                    begin
                        r.write_data = {16'h0, p.code_value_word[15:0]};
                        r.write_size = cci_pkg::SIZE_HALF;
                    end
                    else
                    begin
                        r.write_data = {24'h0, p.code_value_word[7:0]};
                        r.write_size = cci_pkg::SIZE_BYTE;
                    end
                end
            end
            cci_pkg::OP_IF_EQ16:
            begin
                care = ~p.code_value_word[31:16];
                flag_model = ((p.memory_halfword & care) == p.code_value_word[15:0]);
            end
            cci_pkg::OP_END_IF:
                flag_model = 1'b1;
            default: ;
        endcase
        r.condition_true = flag_model;
        // a cheat's last pair re-arms the condition for the next one
        if (p.last_pair)
            flag_model = 1'b1;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Prediction on accepted pairs, checking on accepted results
    always @(posedge clk)
    begin
        cci_pkg::result_t want;
        cci_pkg::result_t predicted;
        if (!rst_n)
        begin
            flag_model   = 1'b1;
            enable_model = cci_pkg::CHEAT_ENABLE_RST;
            mask_model   = cci_pkg::RAM_MASK_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == cci_pkg::CFG_CHEAT_ENABLE)
                    enable_model = cfg_data[0];
                else if (cfg_index == cci_pkg::CFG_RAM_MASK)
                    mask_model = cfg_data;
            end
            if (code_valid && !code_stall)
            begin
                predicted = interpret_pair(code);
                outcome_q.push_back(code_known ? code_known_outcome : predicted);
                pairs_seen++;
            end
            if (result_valid && !result_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, got %p", $time, result);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    report_field("write_request", 32'(want.write_request),
                                 32'(result.write_request));
                    report_field("write_address", 32'(want.write_address),
                                 32'(result.write_address));
                    report_field("write_data", want.write_data, result.write_data);
                    report_field("write_size", 32'(want.write_size), 32'(result.write_size));
                    report_field("condition_true", 32'(want.condition_true),
                                 32'(result.condition_true));
                    if (result.write_request)
                        writes_seen++;
                    if (!result.condition_true)
                        false_conds++;
                end
            end
        end
    end

    // Offer one pair, after idle cycles drawn one at a time, and hold it until taken
    task automatic send_pair(input cci_pkg::code_t p, input bit known,
                             input cci_pkg::result_t outcome);
        while ($urandom_range(99) < send_idle_pct)
        begin
            code_valid <= 1'b0;
            @(posedge clk);
        end
        code               <= p;
        code_known         <= known;
        code_known_outcome <= outcome;
        code_valid         <= 1'b1;
        do @(posedge clk); while (code_stall);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain;
        code_valid <= 1'b0;
        do @(posedge clk); while (outcome_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cci_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cci_pkg::ADDR_W-1:0] d);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic plan_row_t mk_row(input logic [31:0] aw, input logic [31:0] vw,
                                         input logic [15:0] half, input bit last,
                                         input bit known, input cci_pkg::result_t outcome);
        plan_row_t row;
        row.pair.code_address_word = aw;
        row.pair.code_value_word   = vw;
        row.pair.memory_halfword   = half;
        row.pair.last_pair         = last;
        row.known   = known;
        row.outcome = outcome;
        return row;
    endfunction

    // Random pair: mostly real opcodes, compares often rigged to pass
    function automatic cci_pkg::code_t random_pair(input bit last);
        cci_pkg::code_t p;
        int pick;
        p.code_address_word = $urandom;
        p.code_value_word   = $urandom;
        p.memory_halfword   = 16'($urandom);
        p.last_pair         = last;
        pick = $urandom_range(99);
        if (pick < 20)
            p.code_address_word[31:28] = cci_pkg::OP_WRITE32;
        else if (pick < 35)
            p.code_address_word[31:28] = cci_pkg::OP_WRITE16;
        else if (pick < 50)
            p.code_address_word[31:28] = cci_pkg::OP_WRITE8;
        else if (pick < 72)
        begin
            p.code_address_word[31:28] = cci_pkg::OP_IF_EQ16;
            if ($urandom_range(1))
                p.code_value_word[15:0] = p.memory_halfword & ~p.code_value_word[31:16];
        end
        else if (pick < 82)
            p.code_address_word[31:28] = cci_pkg::OP_END_IF;
        return p;
    endfunction

    // A stream of whole cheats with some stray pairs mixed in
    task automatic run_cheats(input int n);
        int sent;
        int len;
        cci_pkg::code_t p;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                p = '0;
                p.code_address_word = $urandom;
                p.code_value_word   = $urandom;
                p.memory_halfword   = 16'($urandom);
                p.last_pair         = 1'($urandom_range(1));
                send_pair(p, 1'b0, '0);
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_pair(random_pair(i == len - 1), 1'b0, '0);
                sent += len;
            end
        end
    endtask

    initial
    begin
        logic [cci_pkg::ADDR_W-1:0] mask_pick;
        bit en_pick;
        cci_pkg::result_t none_true;
        cci_pkg::result_t none_false;
        logic [cci_pkg::OP_W-1:0] odd_ops[11];

        none_true  = '0;
        none_true.condition_true = 1'b1;
        none_false = '0;
        odd_ops = '{4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF};

        // Directed table, reset configuration
        plan.push_back(mk_row(32'h0FFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b1,
                              '{1'b1, 28'h03F_FFFF, 32'hFFFF_FFFF, cci_pkg::SIZE_WORD, 1'b1}));
        plan.push_back(mk_row(32'h1000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1,
                              '{1'b1, 28'h0, 32'h0000_FFFF, cci_pkg::SIZE_HALF, 1'b1}));
        plan.push_back(mk_row(32'h2ABC_DEF1, 32'h1234_5678, 16'h0000, 1'b0, 1'b0, '0));
        // failed compare blocks the writes that follow
        plan.push_back(mk_row(32'h9000_0000, 32'h0000_0001, 16'h0000, 1'b0, 1'b1, none_false));
        plan.push_back(mk_row(32'h0000_0010, 32'hDEAD_BEEF, 16'h0000, 1'b0, 1'b1, none_false));
        plan.push_back(mk_row(32'hF000_0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b1, none_false));
        plan.push_back(mk_row(32'hD000_0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b1, none_true));
        // fully masked compare always passes
        plan.push_back(mk_row(32'h9FFF_FFFF, 32'hFFFF_0000, 16'hFFFF, 1'b1, 1'b1, none_true));
        // failing compare on the last pair: reported false, then re-armed
        plan.push_back(mk_row(32'h9000_0000, 32'h0000_1234, 16'h0000, 1'b1, 1'b1, none_false));
        plan.push_back(mk_row(32'h2000_0001, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b1,
                              '{1'b1, 28'h1, 32'h0000_00FF, cci_pkg::SIZE_BYTE, 1'b1}));
        plan.push_back(mk_row(32'h9123_4567, 32'hFF00_0034, 16'hAB34, 1'b0, 1'b0, '0));
        plan.push_back(mk_row(32'h1765_4321, 32'hCAFE_F00D, 16'h0000, 1'b1, 1'b0, '0));
        foreach (odd_ops[i])
            plan.push_back(mk_row({odd_ops[i], 28'hFFF_FFFF}, 32'hFFFF_FFFF, 16'hFFFF,
                                  i[0], 1'b1, none_true));

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 21;
        recv_idle_pct = 66;
        foreach (plan[i])
            send_pair(plan[i].pair, plan[i].known, plan[i].outcome);
        drain();

        // Random cheats over three idling patterns and several register settings
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 66 : 0;
            recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 21 : 0;
            for (int k = 0; k < 4; k++)
            begin
                case (k)
                    0: begin en_pick = 1'b1; mask_pick = 28'hFFF_FFFF; end
                    1: begin en_pick = 1'b0; mask_pick = 28'($urandom); end
                    2: begin en_pick = 1'b1; mask_pick = 28'h0; end
                    default: begin en_pick = 1'b1; mask_pick = 28'($urandom); end
                endcase
                write_reg(cci_pkg::CFG_CHEAT_ENABLE, {{(cci_pkg::ADDR_W-1){1'b0}}, en_pick});
                write_reg(cci_pkg::CFG_RAM_MASK, mask_pick);
                run_cheats(PAIRS_PER_PHASE);
                drain();
                phases_run++;
            end
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        $display("covered %0d pairs over %0d register settings: %0d writes, %0d false conds",
                 pairs_seen, phases_run + 1, writes_seen, false_conds);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("cheat_code_interpreter_unit_test: PASS");
        else
            $display("cheat_code_interpreter_unit_test: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/cci_pkg.sv
sv/cci_config.sv
sv/cci_decode.sv
sv/cheat_code_interpreter_unit.sv
sv/cci_checker.sv
test/cheat_code_interpreter_unit_test.sv
